// ===== design/bsds_pkg.sv =====
// Shared types and constants for the battery SOC display smoother.
// No dependencies; used by bsds_serial_div, battery_soc_display_smoother and the testbench.
package bsds_pkg;

    // field widths
    localparam int SOC_W  = 7;
    localparam int CAP_W  = 16;
    localparam int CUR_W  = 16;
    localparam int THR_W  = 24;
    localparam int STAT_W = 2;

    // 127 * 65535 < 2**23
    localparam int PROD_W = 23;

    // serial divider: up to 14 quotient bits
    localparam int Q_MAX = 14;
    localparam int SH_W  = 4;
    localparam logic [SH_W-1:0] DIV1_SHIFT = 4'd6;   // raw percent, 7 bits
    localparam logic [SH_W-1:0] DIV2_SHIFT = 4'd13;  // rescaled percent, 14 bits

    // rescale divide: (raw*10000 + 50*div) / (100*div)
    localparam int D2_NUM_W = 21;
    localparam int D2_DEN_W = 14;

    localparam int PCT_SCALE  = 10000;
    localparam int ROUND_HALF = 50;
    localparam int PCT_DIV    = 100;
    localparam int MA_TO_UA   = 1000;

    localparam logic [SOC_W-1:0] SOC_FULL = 7'd100;
    localparam logic [SOC_W-1:0] SOC_HOLD = 7'd99;
    localparam logic [SOC_W-1:0] TGT_SAT  = 7'd101;

    // charger status codes (3 acts as other)
    localparam logic [STAT_W-1:0] STAT_OTHER    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_CHARGING = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] STAT_RSVD     = 2'd3;

    // register indexes
    localparam logic [1:0] REG_UI_FULL   = 2'd0;
    localparam logic [1:0] REG_TAPER_THR = 2'd1;
    localparam logic [1:0] REG_FAST_MODE = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DIV1_GO,
        S_DIV1_WAIT,
        S_SCALE,
        S_DIV2_WAIT,
        S_FINAL
    } state_t;

    typedef struct packed {
        logic            start;
        logic [SH_W-1:0] shift;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== design/bsds_serial_div.sv =====
// Restoring divider, one quotient bit per cycle, quotient length set per request.
// Depends on bsds_pkg.
module bsds_serial_div import bsds_pkg::*; #(
    parameter int N_W = 25,
    parameter int D_W = 18
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  div_req_t         req,
    input  logic [N_W-1:0]   num,
    input  logic [D_W-1:0]   den,
    output div_stat_t        stat,
    output logic [Q_MAX-1:0] quot
);

    localparam int CW = (N_W > D_W + Q_MAX) ? N_W : D_W + Q_MAX;

    logic [CW-1:0]    rem_reg, rem_next;
    logic [CW-1:0]    dsh_reg, dsh_next;
    logic [Q_MAX-1:0] q_reg, q_next;
    logic [SH_W-1:0]  cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             fits;

    always_comb begin
        fits      = (rem_reg >= dsh_reg);
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = CW'(num);
            dsh_next  = CW'(den) << req.shift;
            q_next    = '0;
            cnt_next  = req.shift;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            q_next   = {q_reg[Q_MAX-2:0], fits};
            if (fits) begin
                rem_next = rem_reg - dsh_reg;
            end
            dsh_next = dsh_reg >> 1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = q_reg;

endmodule

// ===== design/battery_soc_display_smoother.sv =====
// Battery SOC display smoother: per-pack accumulate, weighted percent, rescale, step.
// A non-last beat is accepted, then runs 7 shift-add steps over the percent bits.
// A last beat then runs two serial divides (7 and 14 quotient bits, one per cycle) and
// the final step; m_valid rises with s_ready back high in the same cycle. One beat in
// flight at a time; a stalled result holds the next last beat. aresetn is synchronous,
// active low: sums, shown value, taper count, threshold, fast mode clear; UI full to 100.
module battery_soc_display_smoother import bsds_pkg::*; #(
    parameter int MAX_PACKS   = 4,
    parameter int TAPER_LIMIT = 5
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [SOC_W-1:0]         s_pack_soc,
    input  logic [CAP_W-1:0]         s_pack_full_charge,
    input  logic signed [CUR_W-1:0]  s_pack_current,
    input  logic                     s_last_pack,
    input  logic [STAT_W-1:0]        s_charge_status,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [SOC_W-1:0]         m_shown_soc,
    output logic                     m_soc_changed,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [3:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int PK_W  = $clog2(MAX_PACKS + 1);
    localparam int SUM_X = $clog2(MAX_PACKS);
    localparam int WS_W  = PROD_W + SUM_X;
    localparam int FS_W  = CAP_W + SUM_X;
    localparam int CS_W  = CUR_W + SUM_X;
    localparam int UA_W  = CS_W + 10;
    localparam int TC_W  = $clog2(TAPER_LIMIT + 1);
    localparam int DN_W  = (WS_W > D2_NUM_W) ? WS_W : D2_NUM_W;
    localparam int DD_W  = (FS_W > D2_DEN_W) ? FS_W : D2_DEN_W;

    state_t state_reg, state_next;

    logic [SOC_W-1:0]       ui_full_reg, ui_full_next;
    logic [THR_W-1:0]       thr_reg, thr_next;
    logic                   fast_reg, fast_next;

    logic [SOC_W-1:0]       soc_sh_reg, soc_sh_next;
    logic [PROD_W-1:0]      cap_sh_reg, cap_sh_next;
    logic [2:0]             bit_cnt_reg, bit_cnt_next;
    logic                   acc_en_reg, acc_en_next;
    logic                   last_reg, last_next;
    logic [STAT_W-1:0]      status_reg, status_next;

    logic [WS_W-1:0]        ws_reg, ws_next;
    logic [FS_W-1:0]        fs_reg, fs_next;
    logic signed [CS_W-1:0] cs_reg, cs_next;
    logic [PK_W-1:0]        pk_cnt_reg, pk_cnt_next;

    logic [SOC_W-1:0]       tgt_reg, tgt_next;
    logic                   taper_le_reg, taper_le_next;
    logic [SOC_W-1:0]       shown_reg, shown_next;
    logic                   shown_valid_reg, shown_valid_next;
    logic [TC_W-1:0]        taper_cnt_reg, taper_cnt_next;

    logic                   m_valid_reg, m_valid_next;
    logic [SOC_W-1:0]       m_soc_reg, m_soc_next;
    logic                   m_chg_reg, m_chg_next;

    div_req_t               div_req;
    div_stat_t              div_stat;
    logic [DN_W-1:0]        div_num;
    logic [DD_W-1:0]        div_den;
    logic [Q_MAX-1:0]       div_quot;

    logic                   accept;
    logic                   cfg_wr;
    logic                   load;
    logic [UA_W-1:0]        cur_ua;
    logic [SOC_W-1:0]       raw;
    logic [SOC_W-1:0]       dvs;
    logic                   hold_cond;
    logic [TC_W-1:0]        tc_new;
    logic [SOC_W-1:0]       tgt_h;
    logic [SOC_W-1:0]       result;
    logic                   cs_pos;
    logic                   cs_neg;

    bsds_serial_div #(
        .N_W(DN_W),
        .D_W(DD_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .num     (div_num),
        .den     (div_den),
        .stat    (div_stat),
        .quot    (div_quot)
    );

    // final step: taper hold, then first poll takes the target, full status shows 100, else one step toward the target
    always_comb begin
        cs_neg    = cs_reg[CS_W-1];
        cs_pos    = !cs_reg[CS_W-1] && (cs_reg != '0);
        hold_cond = (thr_reg != '0) && (status_reg == STAT_CHARGING) && fast_reg &&
                    (tgt_reg >= SOC_FULL) && (!shown_valid_reg || shown_reg != SOC_FULL);
        if (!taper_le_reg) begin
            tc_new = '0;
        end else if (taper_cnt_reg >= TC_W'(TAPER_LIMIT)) begin
            tc_new = '0;
        end else begin
            tc_new = taper_cnt_reg + 1'b1;
        end
        tgt_h = tgt_reg;
        if (hold_cond && tc_new < TC_W'(TAPER_LIMIT)) begin
            tgt_h = SOC_HOLD;
        end
        if (tgt_h > SOC_FULL) begin
            tgt_h = SOC_FULL;
        end
        if (!shown_valid_reg) begin
            result = tgt_h;
        end else if (status_reg == STAT_FULL) begin
            result = SOC_FULL;
        end else if (tgt_h > shown_reg && cs_pos) begin
            result = shown_reg + 1'b1;
        end else if (tgt_h < shown_reg && cs_neg) begin
            result = shown_reg - 1'b1;
        end else begin
            result = shown_reg;
        end
    end

    always_comb begin
        cur_ua = UA_W'(cs_reg[CS_W-2:0]) * UA_W'(MA_TO_UA);
        raw    = (fs_reg == '0) ? '0 : div_quot[SOC_W-1:0];
        dvs    = (ui_full_reg == '0) ? SOC_W'(1) : ui_full_reg;
    end

    always_comb begin
        state_next       = state_reg;
        ui_full_next     = ui_full_reg;
        thr_next         = thr_reg;
        fast_next        = fast_reg;
        soc_sh_next      = soc_sh_reg;
        cap_sh_next      = cap_sh_reg;
        bit_cnt_next     = bit_cnt_reg;
        acc_en_next      = acc_en_reg;
        last_next        = last_reg;
        status_next      = status_reg;
        ws_next          = ws_reg;
        fs_next          = fs_reg;
        cs_next          = cs_reg;
        pk_cnt_next      = pk_cnt_reg;
        tgt_next         = tgt_reg;
        taper_le_next    = taper_le_reg;
        shown_next       = shown_reg;
        shown_valid_next = shown_valid_reg;
        taper_cnt_next   = taper_cnt_reg;
        m_soc_next       = m_soc_reg;
        m_chg_next       = m_chg_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        div_req.start    = 1'b0;
        div_req.shift    = DIV1_SHIFT;
        div_num          = '0;
        div_den          = '0;
        load             = 1'b0;

        s_ready = (state_reg == S_IDLE);
        accept  = s_valid && s_ready;
        cfg_wr  = psel && penable && pwrite;

        if (cfg_wr) begin
            case (paddr[3:2])
                REG_UI_FULL:   ui_full_next = pwdata[SOC_W-1:0];
                REG_TAPER_THR: thr_next     = pwdata[THR_W-1:0];
                REG_FAST_MODE: fast_next    = pwdata[0];
                default:       ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    soc_sh_next  = s_pack_soc;
                    cap_sh_next  = PROD_W'(s_pack_full_charge);
                    bit_cnt_next = '0;
                    last_next    = s_last_pack;
                    status_next  = s_charge_status;
                    acc_en_next  = (pk_cnt_reg < PK_W'(MAX_PACKS));
                    if (pk_cnt_reg < PK_W'(MAX_PACKS)) begin
                        fs_next     = fs_reg + FS_W'(s_pack_full_charge);
                        cs_next     = cs_reg + CS_W'(s_pack_current);
                        pk_cnt_next = pk_cnt_reg + 1'b1;
                    end
                    state_next = S_MAC;
                end
            end
            S_MAC: begin
                // shift-add: one percent bit per cycle
                if (acc_en_reg && soc_sh_reg[0]) begin
                    ws_next = ws_reg + WS_W'(cap_sh_reg);
                end
                soc_sh_next  = soc_sh_reg >> 1;
                cap_sh_next  = cap_sh_reg << 1;
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == 3'(SOC_W - 1)) begin
                    state_next = last_reg ? S_DIV1_GO : S_IDLE;
                end
            end
            S_DIV1_GO: begin
                div_req.start = 1'b1;
                div_req.shift = DIV1_SHIFT;
                div_num       = DN_W'(ws_reg);
                div_den       = DD_W'(fs_reg);
                taper_le_next = cs_reg[CS_W-1] || (cur_ua <= UA_W'(thr_reg));
                state_next    = S_DIV1_WAIT;
            end
            S_DIV1_WAIT: begin
                if (div_stat.done) begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE: begin
                // nested floor divides fold into one: (raw*10000 + 50*d) / (100*d)
                div_req.start = 1'b1;
                div_req.shift = DIV2_SHIFT;
                div_num       = DN_W'(D2_NUM_W'(raw) * D2_NUM_W'(PCT_SCALE) +
                                      D2_NUM_W'(dvs) * D2_NUM_W'(ROUND_HALF));
                div_den       = DD_W'(D2_DEN_W'(dvs) * D2_DEN_W'(PCT_DIV));
                state_next    = S_DIV2_WAIT;
            end
            S_DIV2_WAIT: begin
                if (div_stat.done) begin
                    tgt_next   = (div_quot >= Q_MAX'(TGT_SAT)) ? TGT_SAT
                                                               : div_quot[SOC_W-1:0];
                    state_next = S_FINAL;
                end
            end
            S_FINAL: begin
                if (!m_valid_reg || m_ready) begin
                    load             = 1'b1;
                    m_valid_next     = 1'b1;
                    m_soc_next       = result;
                    m_chg_next       = !shown_valid_reg || (result != shown_reg);
                    shown_next       = result;
                    shown_valid_next = 1'b1;
                    if (hold_cond) begin
                        taper_cnt_next = tc_new;
                    end
                    ws_next     = '0;
                    fs_next     = '0;
                    cs_next     = '0;
                    pk_cnt_next = '0;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            ui_full_reg     <= SOC_FULL;
            thr_reg         <= '0;
            fast_reg        <= 1'b0;
            ws_reg          <= '0;
            fs_reg          <= '0;
            cs_reg          <= '0;
            pk_cnt_reg      <= '0;
            shown_reg       <= '0;
            shown_valid_reg <= 1'b0;
            taper_cnt_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            ui_full_reg     <= ui_full_next;
            thr_reg         <= thr_next;
            fast_reg        <= fast_next;
            ws_reg          <= ws_next;
            fs_reg          <= fs_next;
            cs_reg          <= cs_next;
            pk_cnt_reg      <= pk_cnt_next;
            shown_reg       <= shown_next;
            shown_valid_reg <= shown_valid_next;
            taper_cnt_reg   <= taper_cnt_next;
            m_valid_reg     <= m_valid_next;
        end
        soc_sh_reg   <= soc_sh_next;
        cap_sh_reg   <= cap_sh_next;
        bit_cnt_reg  <= bit_cnt_next;
        acc_en_reg   <= acc_en_next;
        last_reg     <= last_next;
        status_reg   <= status_next;
        tgt_reg      <= tgt_next;
        taper_le_reg <= taper_le_next;
        m_soc_reg    <= m_soc_next;
        m_chg_reg    <= m_chg_next;
    end

    always_comb begin
        case (paddr[3:2])
            REG_UI_FULL:   prdata = 32'(ui_full_reg);
            REG_TAPER_THR: prdata = 32'(thr_reg);
            REG_FAST_MODE: prdata = 32'(fast_reg);
            default:       prdata = '0;
        endcase
    end

    assign pready        = 1'b1;
    assign m_valid       = m_valid_reg;
    assign m_shown_soc   = m_soc_reg;
    assign m_soc_changed = m_chg_reg;

`ifndef SYNTHESIS
    a_shown_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_shown_soc <= SOC_FULL)
        else $error("shown percent above full");

    a_pack_count: assert property (@(posedge aclk) disable iff (!aresetn)
        pk_cnt_reg <= PK_W'(MAX_PACKS))
        else $error("pack count past limit");

    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.busy |-> (state_reg == S_DIV1_WAIT || state_reg == S_DIV2_WAIT))
        else $error("divider running outside a wait state");

    a_sums_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (ws_reg == '0 && fs_reg == '0 && cs_reg == '0 && pk_cnt_reg == '0))
        else $error("sums not cleared after poll");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for battery_soc_display_smoother: random and directed poll beats,
// an in-bench display predictor, and a scoreboard on the result channel.
// Depends on bsds_pkg and the design sources under design/.
module testbench;
    import bsds_pkg::*;

    localparam int PACK_LIMIT     = 4;
    localparam int TAPER_POLLS    = 5;
    localparam int DRAIN_CYCLES   = 64;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT    = 1000000;

    typedef struct {
        logic [SOC_W-1:0]         soc;
        logic [CAP_W-1:0]         cap;
        logic signed [CUR_W-1:0]  cur;
        logic                     last;
        logic [STAT_W-1:0]        status;
    } pack_reading_t;

    typedef struct {
        logic [SOC_W-1:0] shown_soc;
        logic             changed;
    } display_result_t;

    typedef enum {MIX_GENERIC, MIX_TAPER} poll_mix_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic [SOC_W-1:0]        s_pack_soc;
    logic [CAP_W-1:0]        s_pack_full_charge;
    logic signed [CUR_W-1:0] s_pack_current;
    logic                    s_last_pack;
    logic [STAT_W-1:0]       s_charge_status;
    logic                    m_valid;
    logic                    m_ready;
    logic [SOC_W-1:0]        m_shown_soc;
    logic                    m_soc_changed;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [3:0]              paddr;
    logic [31:0]             pwdata;
    logic [31:0]             prdata;
    logic                    pready;

    battery_soc_display_smoother #(
        .MAX_PACKS   (PACK_LIMIT),
        .TAPER_LIMIT (TAPER_POLLS)
    ) u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_pack_soc         (s_pack_soc),
        .s_pack_full_charge (s_pack_full_charge),
        .s_pack_current     (s_pack_current),
        .s_last_pack        (s_last_pack),
        .s_charge_status    (s_charge_status),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_shown_soc        (m_shown_soc),
        .m_soc_changed      (m_soc_changed),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    // register shadows
    logic [SOC_W-1:0] cfg_ui_full = SOC_FULL;
    logic [THR_W-1:0] cfg_taper_thr = '0;
    logic             cfg_fast_mode = 1'b0;

    // predictor state
    int acc_weighted = 0;
    int acc_capacity = 0;
    int acc_current  = 0;
    int packs_taken  = 0;
    int shown_val    = 0;
    bit shown_ok     = 1'b0;
    int taper_cnt    = 0;

    pack_reading_t   pending_beats_q[$];
    display_result_t expected_display_q[$];
    pack_reading_t   beat_on_bus;

    int sender_idle_pct = 0;
    int rx_stall_pct    = 0;
    int hold_req        = 0;
    int hold_ack        = 0;
    int hold_left       = 0;
    int error_count     = 0;
    int tick_count      = 0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        tick_count++;
        if (tick_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic predict_display(input pack_reading_t rd);
        int raw;
        int div_v;
        int tgt;
        int nxt;
        display_result_t res;
        if (packs_taken < PACK_LIMIT) begin
            acc_weighted += int'(rd.soc) * int'(rd.cap);
            acc_capacity += int'(rd.cap);
            acc_current  += int'(rd.cur);
            packs_taken++;
        end
        if (!rd.last)
            return;
        raw   = (acc_capacity == 0) ? 0 : acc_weighted / acc_capacity;
        div_v = (cfg_ui_full == 0) ? 1 : int'(cfg_ui_full);
        tgt   = (raw * PCT_SCALE / div_v + ROUND_HALF) / PCT_DIV;
        // fast-charge taper hold at 99
        if (cfg_taper_thr != 0 && rd.status == STAT_CHARGING && cfg_fast_mode &&
            tgt >= int'(SOC_FULL) && (!shown_ok || shown_val != int'(SOC_FULL))) begin
            if (acc_current * MA_TO_UA <= int'(cfg_taper_thr))
                taper_cnt = (taper_cnt >= TAPER_POLLS) ? 0 : taper_cnt + 1;
            else
                taper_cnt = 0;
            if (taper_cnt < TAPER_POLLS)
                tgt = int'(SOC_HOLD);
        end
        if (tgt > int'(SOC_FULL))
            tgt = int'(SOC_FULL);
        if (!shown_ok)
            nxt = tgt;
        else if (rd.status == STAT_FULL)
            nxt = int'(SOC_FULL);
        else begin
            nxt = shown_val;
            if (tgt > shown_val && acc_current > 0)
                nxt = shown_val + 1;
            else if (tgt < shown_val && acc_current < 0)
                nxt = shown_val - 1;
        end
        if (nxt < 0)
            nxt = 0;
        if (nxt > int'(SOC_FULL))
            nxt = int'(SOC_FULL);
        res.shown_soc = nxt[SOC_W-1:0];
        res.changed   = !shown_ok || (nxt != shown_val);
        shown_val = nxt;
        shown_ok  = 1'b1;
        expected_display_q.push_back(res);
        acc_weighted = 0;
        acc_capacity = 0;
        acc_current  = 0;
        packs_taken  = 0;
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                predict_display(beat_on_bus);
            if (!s_valid || s_ready) begin
                if (pending_beats_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    beat_on_bus = pending_beats_q.pop_front();
                    s_valid            <= 1'b1;
                    s_pack_soc         <= beat_on_bus.soc;
                    s_pack_full_charge <= beat_on_bus.cap;
                    s_pack_current     <= beat_on_bus.cur;
                    s_last_pack        <= beat_on_bus.last;
                    s_charge_status    <= beat_on_bus.status;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge aclk) begin
        if (hold_ack != hold_req) begin
            hold_ack  <= hold_req;
            hold_left <= RX_HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        display_result_t exp_res;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_display_q.size() == 0) begin
                    $display("%0t: unexpected result beat, shown_soc %0d changed %0d",
                             $time, m_shown_soc, m_soc_changed);
                    error_count++;
                end else begin
                    exp_res = expected_display_q.pop_front();
                    if (m_shown_soc !== exp_res.shown_soc) begin
                        $display("%0t: shown_soc expected %0d, actual %0d",
                                 $time, exp_res.shown_soc, m_shown_soc);
                        error_count++;
                    end
                    if (m_soc_changed !== exp_res.changed) begin
                        $display("%0t: soc_changed expected %0d, actual %0d",
                                 $time, exp_res.changed, m_soc_changed);
                        error_count++;
                    end
                end
            end
            m_ready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_UI_FULL:   cfg_ui_full   = val[SOC_W-1:0];
            REG_TAPER_THR: cfg_taper_thr = val[THR_W-1:0];
            REG_FAST_MODE: cfg_fast_mode = val[0];
            default: ;
        endcase
    endtask

    task automatic write_all_regs(input logic [6:0] ui, input logic [23:0] thr, input bit fast);
        write_reg(REG_UI_FULL, 32'(ui));
        write_reg(REG_TAPER_THR, 32'(thr));
        write_reg(REG_FAST_MODE, 32'(fast));
    endtask

    // wait for the bus and the scoreboard to empty, then let the block settle
    task automatic wait_drained();
        while (pending_beats_q.size() != 0 || s_valid || expected_display_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic void push_reading(input logic [6:0] soc, input logic [15:0] cap,
                                         input int cur, input bit last, input logic [1:0] st);
        pack_reading_t rd;
        rd.soc    = soc;
        rd.cap    = cap;
        rd.cur    = cur[CUR_W-1:0];
        rd.last   = last;
        rd.status = st;
        pending_beats_q.push_back(rd);
    endfunction

    function automatic pack_reading_t make_reading(input poll_mix_t mix, input bit dip);
        pack_reading_t rd;
        int v;
        if (mix == MIX_TAPER && !dip) begin
            rd.soc = SOC_W'($urandom_range(127, 95));
            rd.cap = CAP_W'($urandom_range(65535, 1000));
            if ($urandom_range(99) < 80)
                v = int'($urandom_range(14)) - 3;
            else
                v = int'($urandom_range(4000)) - 2000;
        end else if (mix == MIX_TAPER) begin
            // discharge poll that pulls the shown value back down
            rd.soc = SOC_W'($urandom_range(90, 40));
            rd.cap = CAP_W'($urandom_range(65535, 1000));
            v = -int'($urandom_range(500, 1));
        end else begin
            rd.soc = ($urandom_range(99) < 90) ? SOC_W'($urandom_range(100))
                                               : SOC_W'($urandom_range(127, 101));
            rd.cap = ($urandom_range(99) < 10) ? '0 : CAP_W'($urandom);
            v = ($urandom_range(1)) ? int'($urandom) : int'($urandom_range(600)) - 300;
        end
        rd.cur  = v[CUR_W-1:0];
        rd.last = 1'b0;
        if (mix == MIX_TAPER) begin
            v = $urandom_range(99);
            rd.status = (v < 85) ? STAT_CHARGING : (v < 92) ? STAT_FULL
                                                            : STAT_W'($urandom_range(3));
        end else begin
            rd.status = STAT_W'($urandom_range(3));
        end
        return rd;
    endfunction

    // one poll: mostly 1..MAX_PACKS beats, sometimes overlong
    function automatic int queue_poll(input poll_mix_t mix);
        int n;
        int r;
        bit dip;
        pack_reading_t rd;
        r   = $urandom_range(99);
        n   = (r < 88) ? $urandom_range(PACK_LIMIT, 1)
                       : $urandom_range(PACK_LIMIT + 3, PACK_LIMIT + 1);
        dip = ($urandom_range(99) < 12);
        for (int i = 0; i < n; i++) begin
            rd = make_reading(mix, dip);
            rd.last = (i == n - 1);
            pending_beats_q.push_back(rd);
        end
        return n;
    endfunction

    task automatic run_phase(input logic [6:0] ui, input logic [23:0] thr, input bit fast,
                             input int s_idle, input int m_stall, input int n_items,
                             input poll_mix_t mix, input bit long_hold);
        int queued;
        wait_drained();
        write_all_regs(ui, thr, fast);
        sender_idle_pct = s_idle;
        rx_stall_pct    = m_stall;
        if (long_hold)
            hold_req++;
        queued = 0;
        while (queued < n_items / 2)
            queued += queue_poll(mix);
        // sender pause: nothing new until every result is back
        wait_drained();
        while (queued < n_items)
            queued += queue_poll(mix);
    endtask

    initial begin
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_pack_soc         = '0;
        s_pack_full_charge = '0;
        s_pack_current     = '0;
        s_last_pack        = 1'b0;
        s_charge_status    = '0;
        m_ready            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed: zero capacity, field extremes, status 3, overlong poll, full status
        write_all_regs(7'd100, 24'd0, 1'b0);
        push_reading(7'd0, 16'd0, 0, 1'b1, STAT_OTHER);
        push_reading(7'd100, 16'hFFFF, 32767, 1'b1, STAT_CHARGING);
        push_reading(7'd127, 16'hFFFF, -32768, 1'b1, STAT_RSVD);
        for (int i = 0; i < 5; i++)
            push_reading(7'd50, 16'd1000, 100, 1'b0, STAT_OTHER);
        push_reading(7'd100, 16'hFFFF, 200, 1'b1, STAT_FULL);
        push_reading(7'd0, 16'hFFFF, -32768, 1'b0, STAT_OTHER);
        push_reading(7'd0, 16'hFFFF, -32768, 1'b1, STAT_OTHER);
        push_reading(7'd100, 16'd0, 5, 1'b1, STAT_CHARGING);
        run_phase(7'd100, 24'd0, 1'b0, 0, 0, 60, MIX_GENERIC, 1'b0);

        run_phase(7'd80, 24'd50000, 1'b1, 0, 0, 140, MIX_TAPER, 1'b1);
        run_phase(7'd1, 24'd10000000, 1'b1, 60, 0, 110, MIX_GENERIC, 1'b0);

        // zero full-scale setting acts as one
        wait_drained();
        write_all_regs(7'd0, 24'hFFFFFF, 1'b0);
        push_reading(7'd60, 16'd100, 10, 1'b1, STAT_CHARGING);
        push_reading(7'd1, 16'd1, 1, 1'b1, STAT_OTHER);
        run_phase(7'd0, 24'hFFFFFF, 1'b0, 0, 60, 100, MIX_GENERIC, 1'b0);

        run_phase(7'd100, 24'd1, 1'b1, 36, 36, 110, MIX_TAPER, 1'b0);
        run_phase(7'd55, 24'd2000000, 1'b0, 36, 36, 100, MIX_GENERIC, 1'b0);
        run_phase(7'd127, 24'd30000, 1'b1, 0, 0, 80, MIX_TAPER, 1'b0);

        wait_drained();
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
